>>> hw/rtl/rfsg_pkg.sv
package rfsg_pkg;

	localparam int FRAME_BYTES  = 22;
	localparam int BUTTON_COUNT = 16;
	localparam int AXIS_COUNT   = 6;
	localparam int COUNT_WIDTH  = 16;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] INPUT_TYPE       = 8'h01;
	localparam logic [1:0] FLAG_ACTIVE      = 2'b01;
	localparam logic [1:0] FLAG_LOW_LATENCY = 2'b10;

	typedef enum logic [1:0] {
		REQ_OPEN  = 2'd0,
		REQ_BYTE  = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_CLOSE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_AXIS   = 2'd1,
		KIND_PRESS  = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_GAMEPAD  = 3'd2;
	localparam logic [2:0] ST_LOCKED   = 3'd3;
	localparam logic [2:0] ST_PORTAL   = 3'd4;
	localparam logic [2:0] ST_INTERNAL = 3'd5;

	localparam logic [1:0] CFG_LEASE   = 2'd0;
	localparam logic [1:0] CFG_ACK     = 2'd1;
	localparam logic [1:0] CFG_LIMIT   = 2'd2;
	localparam logic [1:0] CFG_VERSION = 2'd3;

	// one unit of work for the result sequencer
	typedef struct packed {
		logic                                    frame_ok;
		logic                                    has_status;
		logic                                    has_clear;
		logic                                    ack;
		logic                                    close;
		logic [2:0]                              code;
		logic [1:0]                              flags;
		logic [31:0]                             seq;
		logic [31:0]                             stream;
		logic [15:0]                             held;
		logic [AXIS_COUNT-1:0][15:0]             axes;
		logic [BUTTON_COUNT-1:0][COUNT_WIDTH-1:0] counts;
	} job_t;

endpackage

>>> hw/rtl/remote_frame_session_guard.sv
// flow: an item is classified in the cycle it is taken; its job is registered in the
// job queue and each result in the output register; one input transfer per cycle while
// the two-entry job queue has room; results leave one per cycle while the sink is ready,
// up to 23 for a good frame (6 axes, 16 buttons, ack)
// reset: asynchronous active low, clears the session, counters and registers to defaults
module remote_frame_session_guard (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// socket_id, now_ms, portal_active, gamepad_connected, data_byte, transport_ok
	input  logic [55:0]  s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	// byte_last
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status_code, status_flags, ack_sequence, held mask, session number,
	// element_index, axis_value, press counter, close_socket
	output logic [127:0] m_tdata,
	// result_kind
	output logic [1:0]   m_tuser,
	// last_result
	output logic         m_tlast
);

	logic           acc, push, full, pop, qvalid;
	rfsg_pkg::job_t job, head;

	// input transfer
	assign acc      = s_tvalid && s_tready;
	assign s_tready = !full;

	rfsg_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.acc               (acc),
		.req_type          (s_tuser),
		.socket_id         (s_tdata[7:0]),
		.now_ms            (s_tdata[39:8]),
		.portal_active     (s_tdata[40]),
		.gamepad_connected (s_tdata[41]),
		.data_byte         (s_tdata[49:42]),
		.byte_last         (s_tlast),
		.transport_ok      (s_tdata[50]),
		.push              (push),
		.job               (job)
	);

	// decouples classification from result sequencing
	rfsg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job),
		.full   (full),
		.pop    (pop),
		.valid  (qvalid),
		.head   (head)
	);

	rfsg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (qvalid),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// no job may be written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("job queue overflow");

	// popping needs a job
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> qvalid)
		else $error("job queue underflow");

	// axis results only carry valid axis indices
	a_axis_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == rfsg_pkg::KIND_AXIS) |->
		(m_tdata[88:85] < 4'(rfsg_pkg::AXIS_COUNT)))
		else $error("axis index out of range");

	// an ok status never drops the connection
	a_ok_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == rfsg_pkg::KIND_STATUS && m_tdata[2:0] == rfsg_pkg::ST_OK)
		|-> !m_tdata[121])
		else $error("ok status with close");

endmodule

>>> hw/rtl/rfsg_front.sv
module rfsg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                acc,
	input  logic [1:0]          req_type,
	input  logic [7:0]          socket_id,
	input  logic [31:0]         now_ms,
	input  logic                portal_active,
	input  logic                gamepad_connected,
	input  logic [7:0]          data_byte,
	input  logic                byte_last,
	input  logic                transport_ok,
	output logic                push,
	output rfsg_pkg::job_t      job
);

	logic [15:0] lease_timeout_q, ack_interval_q;
	logic [14:0] axis_limit_q;
	logic [7:0]  version_q;

	logic        owner_valid_q, sequence_seen_q;
	logic [7:0]  owner_socket_q;
	logic [31:0] session_q, lease_time_q, ack_time_q, last_seq_q;
	logic [15:0] held_q;
	logic [4:0]  byte_count_q;
	logic [rfsg_pkg::BUTTON_COUNT-1:0][rfsg_pkg::COUNT_WIDTH-1:0] counts_q;
	logic [rfsg_pkg::FRAME_BYTES-1:0][7:0] fb_q;

	logic [rfsg_pkg::FRAME_BYTES-1:0][7:0] fb_cur;
	logic [31:0] seq, dseq, dlease, dack;
	logic [15:0] fheld, fpressed;
	logic [rfsg_pkg::AXIS_COUNT-1:0][15:0] fax;
	logic [rfsg_pkg::BUTTON_COUNT-1:0][rfsg_pkg::COUNT_WIDTH-1:0] counts_inc;
	logic        content_ok, is_owner, ack;
	logic [4:0]  len;
	logic signed [16:0] v17, lim17;
	logic [2:0]  ocode;

	// next-state controls
	logic do_clear, do_open, do_accept;
	logic [4:0] byte_count_d;

	always_comb begin
		for (int i = 0; i < rfsg_pkg::FRAME_BYTES; i++)
			fb_cur[i] = (byte_count_q == 5'(i)) ? data_byte : fb_q[i];
		seq      = {fb_cur[5], fb_cur[4], fb_cur[3], fb_cur[2]};
		fheld    = {fb_cur[7], fb_cur[6]};
		fpressed = {fb_cur[9], fb_cur[8]};
		lim17    = $signed({2'b00, axis_limit_q});
		content_ok = (fb_cur[0] == version_q) && (fb_cur[1] == rfsg_pkg::INPUT_TYPE) &&
			((fpressed & ~fheld) == 16'h0000);
		for (int i = 0; i < rfsg_pkg::AXIS_COUNT; i++) begin
			fax[i] = {fb_cur[11 + 2 * i], fb_cur[10 + 2 * i]};
			v17 = $signed({fax[i][15], fax[i]});
			if (v17 > lim17 || v17 < -lim17)
				content_ok = 1'b0;
		end
		dseq = seq - last_seq_q;
		if (sequence_seen_q && (dseq == 32'h0 || dseq[31]))
			content_ok = 1'b0;
		for (int i = 0; i < rfsg_pkg::BUTTON_COUNT; i++)
			counts_inc[i] = fpressed[i] ? counts_q[i] + 1'b1 : counts_q[i];
		dack   = now_ms - ack_time_q;
		dlease = now_ms - lease_time_q;
		ack    = (fpressed != 16'h0000) || (dack >= {16'h0000, ack_interval_q});
		is_owner = owner_valid_q && (owner_socket_q == socket_id);
		len    = (byte_count_q < 5'd31) ? byte_count_q + 5'd1 : byte_count_q;
		ocode  = portal_active ? rfsg_pkg::ST_PORTAL :
			(gamepad_connected ? rfsg_pkg::ST_GAMEPAD : rfsg_pkg::ST_OK);

		do_clear     = 1'b0;
		do_open      = 1'b0;
		do_accept    = 1'b0;
		byte_count_d = byte_count_q;
		push         = 1'b0;
		job          = '0;
		job.stream   = session_q;
		job.held     = held_q;
		job.flags    = owner_valid_q ? (rfsg_pkg::FLAG_ACTIVE | rfsg_pkg::FLAG_LOW_LATENCY) : 2'b00;

		case (rfsg_pkg::req_t'(req_type))
			rfsg_pkg::REQ_OPEN: begin
				if (ocode == rfsg_pkg::ST_OK && !owner_valid_q) begin
					do_open = 1'b1;
				end else begin
					push = 1'b1;
					job.has_status = 1'b1;
					job.close = 1'b1;
					job.code = (ocode == rfsg_pkg::ST_OK) ? rfsg_pkg::ST_LOCKED : ocode;
				end
			end
			rfsg_pkg::REQ_BYTE: begin
				byte_count_d = len;
				if (byte_last) begin
					byte_count_d = 5'd0;
					push = 1'b1;
					job.has_status = 1'b1;
					job.close = 1'b1;
					if (gamepad_connected) begin
						job.code = rfsg_pkg::ST_GAMEPAD;
						job.has_clear = is_owner;
						do_clear = is_owner;
					end else if (!is_owner) begin
						job.code = rfsg_pkg::ST_INTERNAL;
					end else if (!transport_ok || len != 5'(rfsg_pkg::FRAME_BYTES)) begin
						job.code = rfsg_pkg::ST_INVALID;
						job.has_clear = 1'b1;
						do_clear = 1'b1;
					end else if (!content_ok) begin
						job.code = rfsg_pkg::ST_INVALID;
						job.seq = seq;
						job.has_clear = 1'b1;
						do_clear = 1'b1;
					end else begin
						do_accept = 1'b1;
						job.frame_ok = 1'b1;
						job.has_status = 1'b0;
						job.close = 1'b0;
						job.code = rfsg_pkg::ST_OK;
						job.ack = ack;
						job.seq = seq;
						job.held = fheld;
						job.axes = fax;
						job.counts = counts_inc;
					end
				end
			end
			rfsg_pkg::REQ_TICK: begin
				if (owner_valid_q && (portal_active || gamepad_connected ||
					dlease > {16'h0000, lease_timeout_q})) begin
					push = 1'b1;
					job.has_clear = 1'b1;
					job.close = 1'b1;
					do_clear = 1'b1;
				end
			end
			rfsg_pkg::REQ_CLOSE: begin
				if (is_owner) begin
					push = 1'b1;
					job.has_clear = 1'b1;
					do_clear = 1'b1;
				end
			end
			default: ;
		endcase
		push = push & acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lease_timeout_q <= 16'd500;
			ack_interval_q  <= 16'd200;
			axis_limit_q    <= 15'd1000;
			version_q       <= 8'd1;
			owner_valid_q   <= 1'b0;
			owner_socket_q  <= '0;
			session_q       <= '0;
			lease_time_q    <= '0;
			ack_time_q      <= '0;
			last_seq_q      <= '0;
			sequence_seen_q <= 1'b0;
			held_q          <= '0;
			counts_q        <= '0;
			byte_count_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rfsg_pkg::CFG_LEASE:   lease_timeout_q <= cfg_data;
					rfsg_pkg::CFG_ACK:     ack_interval_q  <= cfg_data;
					rfsg_pkg::CFG_LIMIT:   axis_limit_q    <= cfg_data[14:0];
					rfsg_pkg::CFG_VERSION: version_q       <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (acc) begin
				byte_count_q <= byte_count_d;
				if (do_clear || do_open) begin
					owner_valid_q   <= do_open;
					owner_socket_q  <= do_open ? socket_id : 8'd0;
					lease_time_q    <= do_open ? now_ms : 32'd0;
					ack_time_q      <= '0;
					last_seq_q      <= '0;
					sequence_seen_q <= 1'b0;
					held_q          <= '0;
					counts_q        <= '0;
				end
				if (do_open)
					session_q <= session_q + 32'd1;
				if (do_accept) begin
					held_q          <= fheld;
					counts_q        <= counts_inc;
					lease_time_q    <= now_ms;
					last_seq_q      <= seq;
					sequence_seen_q <= 1'b1;
					if (ack)
						ack_time_q <= now_ms;
				end
			end
		end
	end

	// frame bytes beyond the frame length are counted but dropped
	always_ff @(posedge clk) begin
		if (acc && req_type == rfsg_pkg::REQ_BYTE && byte_count_q < 5'(rfsg_pkg::FRAME_BYTES))
			fb_q[byte_count_q] <= data_byte;
	end

endmodule

>>> hw/rtl/rfsg_queue.sv
module rfsg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rfsg_pkg::job_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output rfsg_pkg::job_t head
);

	rfsg_pkg::job_t mem_q [rfsg_pkg::QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'(rfsg_pkg::QUEUE_DEPTH));
	assign valid = (cnt_q != 2'd0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

>>> hw/rtl/rfsg_back.sv
module rfsg_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  rfsg_pkg::job_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [127:0]   m_tdata,
	output logic [1:0]     m_tuser,
	output logic           m_tlast
);

	logic [4:0]  step_q;
	logic        adv, r_last, r_close;
	logic [1:0]  r_kind, r_flags;
	logic [2:0]  r_code;
	logic [31:0] r_seq;
	logic [15:0] r_held, r_axis, r_press;
	logic [3:0]  r_idx, bidx;
	logic        m_tvalid_q;
	logic [127:0] m_tdata_q;
	logic [1:0]   m_tuser_q;
	logic         m_tlast_q;

	always_comb begin
		r_kind  = rfsg_pkg::KIND_CLEAR;
		r_code  = rfsg_pkg::ST_OK;
		r_flags = 2'b00;
		r_seq   = 32'h0;
		r_held  = 16'h0;
		r_idx   = 4'h0;
		r_axis  = 16'h0;
		r_press = 16'h0;
		r_close = head.close;
		r_last  = 1'b1;
		bidx    = 4'(step_q - 5'(rfsg_pkg::AXIS_COUNT));
		if (head.frame_ok) begin
			r_seq  = head.seq;
			r_held = head.held;
			if (step_q < 5'(rfsg_pkg::AXIS_COUNT)) begin
				r_kind = rfsg_pkg::KIND_AXIS;
				r_idx  = step_q[3:0];
				r_axis = head.axes[step_q[2:0]];
				r_last = 1'b0;
			end else if (step_q < 5'(rfsg_pkg::AXIS_COUNT + rfsg_pkg::BUTTON_COUNT)) begin
				r_kind  = rfsg_pkg::KIND_PRESS;
				r_idx   = bidx;
				r_press = head.counts[bidx];
				r_last  = (step_q == 5'(rfsg_pkg::AXIS_COUNT + rfsg_pkg::BUTTON_COUNT - 1))
					&& !head.ack;
			end else begin
				r_kind  = rfsg_pkg::KIND_STATUS;
				r_code  = rfsg_pkg::ST_OK;
				r_flags = head.flags;
			end
		end else if (head.has_status && step_q == 5'd0) begin
			r_kind  = rfsg_pkg::KIND_STATUS;
			r_code  = head.code;
			r_flags = head.flags;
			r_seq   = head.seq;
			r_held  = head.held;
			r_last  = !head.has_clear;
		end
		adv = valid && (!m_tvalid_q || m_tready);
		pop = adv && r_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv)
				step_q <= r_last ? 5'd0 : step_q + 5'd1;
			if (adv)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tuser_q <= r_kind;
			m_tlast_q <= r_last;
			m_tdata_q <= {6'h00, r_close, r_press, r_axis, r_idx, head.stream, r_held, r_seq,
				r_flags, r_code};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> tb/remote_frame_session_guard_test.sv
`timescale 1ns / 100ps

module remote_frame_session_guard_test;
	import rfsg_pkg::*;

	// one expected result, fields at the block's widths
	typedef struct {
		kind_t       kind;
		logic [2:0]  code;
		logic [1:0]  flags;
		logic [31:0] seq;
		logic [15:0] held;
		logic [31:0] stream;
		logic [3:0]  idx;
		logic [15:0] axis;
		logic [15:0] press;
		logic        close;
		logic        last;
	} guard_result_t;

	localparam int CYCLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [55:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	remote_frame_session_guard u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		// socket_id, now_ms, portal_active, gamepad_connected, data_byte, transport_ok
		.s_tdata  (s_tdata),
		// req_type
		.s_tuser  (s_tuser),
		// byte_last
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		// status_code, status_flags, ack_sequence, held mask, session number,
		// element_index, axis_value, press counter, close_socket
		.m_tdata  (m_tdata),
		// result_kind
		.m_tuser  (m_tuser),
		// last_result
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow registers
	logic [15:0] lease_timeout;
	logic [15:0] ack_interval;
	logic [14:0] axis_limit;
	logic [7:0]  proto_version;

	// shadow session state
	logic        owner_valid;
	logic [7:0]  owner_socket;
	logic [31:0] session_count;
	logic [31:0] lease_start;
	logic [31:0] ack_start;
	logic [31:0] last_seq;
	logic        seq_seen;
	logic [15:0] held_mask;
	logic [15:0] press_counts [16];
	logic [15:0] axis_shadow [6];
	logic [7:0]  frame_bytes [FRAME_BYTES];
	logic [4:0]  byte_count;

	guard_result_t expected_results [$];
	int mismatches;
	int sender_idle_pct;
	int sink_stall_pct;
	logic [31:0] now_ms;

	// session bookkeeping

	function automatic void clear_session();
		owner_valid = 1'b0;
		owner_socket = '0;
		lease_start = '0;
		ack_start = '0;
		last_seq = '0;
		seq_seen = 1'b0;
		held_mask = '0;
		for (int i = 0; i < 16; i++) press_counts[i] = '0;
		for (int i = 0; i < 6; i++) axis_shadow[i] = '0;
	endfunction

	function automatic guard_result_t base_result(kind_t k, logic cl);
		guard_result_t r;
		r.kind = k;
		r.code = ST_OK;
		r.flags = '0;
		r.seq = last_seq;
		r.held = held_mask;
		r.stream = session_count;
		r.idx = '0;
		r.axis = '0;
		r.press = '0;
		r.close = cl;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void push_status(logic [2:0] code, logic [31:0] seq, logic cl);
		guard_result_t r;
		r = base_result(KIND_STATUS, cl);
		r.code = code;
		r.flags = owner_valid ? (FLAG_ACTIVE | FLAG_LOW_LATENCY) : 2'b00;
		r.seq = seq;
		expected_results.push_back(r);
	endfunction

	function automatic void push_clear(logic cl);
		clear_session();
		expected_results.push_back(base_result(KIND_CLEAR, cl));
	endfunction

	function automatic logic [15:0] frame_word(int at);
		return {frame_bytes[at + 1], frame_bytes[at]};
	endfunction

	// checks a completed frame and queues its results
	function automatic void judge_frame(logic [7:0] sock, logic [31:0] now,
			logic gp, logic tok);
		logic [4:0]  len;
		logic        is_owner;
		logic        ok;
		logic        ack;
		logic [31:0] seq;
		logic [31:0] seq_gap;
		logic [15:0] held;
		logic [15:0] pressed;
		logic [15:0] ax [6];
		int          v;
		guard_result_t r;
		len = byte_count;
		byte_count = '0;
		is_owner = owner_valid && owner_socket == sock;
		if (gp) begin
			push_status(ST_GAMEPAD, '0, 1'b1);
			if (is_owner) push_clear(1'b1);
			return;
		end
		if (!is_owner) begin
			push_status(ST_INTERNAL, '0, 1'b1);
			return;
		end
		if (!tok || len != FRAME_BYTES) begin
			push_status(ST_INVALID, '0, 1'b1);
			push_clear(1'b1);
			return;
		end
		seq = {frame_word(4), frame_word(2)};
		held = frame_word(6);
		pressed = frame_word(8);
		ok = frame_bytes[0] == proto_version && frame_bytes[1] == INPUT_TYPE &&
			(pressed & ~held) == 16'h0;
		for (int i = 0; i < AXIS_COUNT; i++) begin
			ax[i] = frame_word(10 + 2 * i);
			v = $signed(ax[i]);
			if (v > int'(axis_limit) || v < -int'(axis_limit)) ok = 1'b0;
		end
		seq_gap = seq - last_seq;
		if (ok && seq_seen && !(seq_gap != 0 && !seq_gap[31])) ok = 1'b0;
		if (!ok) begin
			push_status(ST_INVALID, seq, 1'b1);
			push_clear(1'b1);
			return;
		end
		held_mask = held;
		for (int i = 0; i < BUTTON_COUNT; i++)
			if (pressed[i]) press_counts[i] = press_counts[i] + 16'd1;
		for (int i = 0; i < AXIS_COUNT; i++) axis_shadow[i] = ax[i];
		lease_start = now;
		last_seq = seq;
		seq_seen = 1'b1;
		ack = pressed != 0 || (now - ack_start) >= {16'h0, ack_interval};
		if (ack) ack_start = now;
		for (int i = 0; i < AXIS_COUNT; i++) begin
			r = base_result(KIND_AXIS, 1'b0);
			r.idx = 4'(i);
			r.axis = axis_shadow[i];
			expected_results.push_back(r);
		end
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			r = base_result(KIND_PRESS, 1'b0);
			r.idx = 4'(i);
			r.press = press_counts[i];
			expected_results.push_back(r);
		end
		if (ack) push_status(ST_OK, seq, 1'b0);
	endfunction

	function automatic void predict_guard(req_t req, logic [7:0] sock, logic [31:0] now,
			logic portal, logic gp, logic [7:0] data, logic last, logic tok);
		int n0;
		n0 = expected_results.size();
		case (req)
			REQ_OPEN: begin
				if (!portal && !gp && !owner_valid) begin
					clear_session();
					owner_valid = 1'b1;
					owner_socket = sock;
					lease_start = now;
					session_count = session_count + 1;
				end else begin
					push_status(portal ? ST_PORTAL : (gp ? ST_GAMEPAD : ST_LOCKED),
						'0, 1'b1);
				end
			end
			REQ_BYTE: begin
				if (byte_count < FRAME_BYTES) frame_bytes[byte_count] = data;
				if (byte_count < 5'd31) byte_count = byte_count + 5'd1;
				if (last) judge_frame(sock, now, gp, tok);
			end
			REQ_TICK: begin
				if (owner_valid && (portal || gp || (now - lease_start) > {16'h0, lease_timeout}))
					push_clear(1'b1);
			end
			default: begin
				if (owner_valid && owner_socket == sock) push_clear(1'b0);
			end
		endcase
		if (expected_results.size() > n0) expected_results[$].last = 1'b1;
	endfunction

	// stimulus plumbing

	// one input transfer; returns at the edge where it was taken
	task automatic send_event(req_t req, logic [7:0] sock, logic portal, logic gp,
			logic [7:0] data, logic last, logic tok);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tlast <= last;
		s_tdata <= {5'b0, tok, data, gp, portal, now_ms, sock};
		do @(posedge clk); while (!s_tready);
		predict_guard(req, sock, now_ms, portal, gp, data, last, tok);
	endtask

	task automatic advance_time(int unsigned lo, int unsigned hi);
		now_ms = now_ms + $urandom_range(hi, lo);
	endtask

	// no results left and the block given time to finish silent items
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_LEASE: lease_timeout = value;
			CFG_ACK:   ack_interval = value;
			CFG_LIMIT: axis_limit = value[14:0];
			default:   proto_version = value[7:0];
		endcase
	endtask

	task automatic set_regs(logic [15:0] lease, logic [15:0] ackv, logic [15:0] lim,
			logic [15:0] ver);
		wait_idle();
		write_reg(CFG_LEASE, lease);
		write_reg(CFG_ACK, ackv);
		write_reg(CFG_LIMIT, lim);
		write_reg(CFG_VERSION, ver);
		cfg_we <= 1'b0;
	endtask

	// sends len bytes of a frame; bytes past the frame body are filler
	task automatic send_frame(logic [7:0] sock, logic [7:0] ver, logic [7:0] typ,
			logic [31:0] seq, logic [15:0] held, logic [15:0] pressed,
			logic [5:0][15:0] axes, int len, logic tok, logic gp);
		logic [7:0] body [FRAME_BYTES];
		logic       last;
		body[0] = ver;
		body[1] = typ;
		{body[5], body[4], body[3], body[2]} = seq;
		{body[7], body[6]} = held;
		{body[9], body[8]} = pressed;
		for (int i = 0; i < 6; i++) {body[11 + 2 * i], body[10 + 2 * i]} = axes[i];
		for (int i = 0; i < len; i++) begin
			last = i == len - 1;
			send_event(REQ_BYTE, sock, 1'($urandom_range(0, 1)),
				last ? gp : 1'($urandom_range(0, 1)),
				i < FRAME_BYTES ? body[i] : 8'($urandom), last,
				last ? tok : 1'($urandom_range(0, 1)));
		end
	endtask

	function automatic logic [5:0][15:0] legal_axes();
		logic [5:0][15:0] a;
		for (int i = 0; i < 6; i++) begin
			case ($urandom_range(0, 3))
				0: a[i] = 16'(axis_limit);
				1: a[i] = 16'(-int'(axis_limit));
				default: a[i] = 16'($urandom_range(0, 2 * axis_limit) - axis_limit);
			endcase
		end
		return a;
	endfunction

	// well-formed frame from the current owner with random content
	task automatic send_good_frame(logic [31:0] step);
		logic [15:0] held;
		held = 16'($urandom);
		advance_time(0, 150);
		send_frame(owner_socket, proto_version, INPUT_TYPE, last_seq + step, held,
			16'($urandom) & held & ($urandom_range(0, 2) == 0 ? 16'h0 : 16'hFFFF),
			legal_axes(), FRAME_BYTES, 1'b1, 1'b0);
	endtask

	task automatic open_session(logic [7:0] sock);
		send_event(REQ_OPEN, sock, 1'b0, 1'b0, 8'($urandom), 1'b0, 1'b0);
	endtask

	// named tests

	task automatic test_open_rules();
		send_event(REQ_OPEN, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
		send_event(REQ_OPEN, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b1);
		open_session(8'hA5);
		send_event(REQ_OPEN, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		send_event(REQ_CLOSE, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		send_event(REQ_CLOSE, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
	endtask

	task automatic test_frame_checks();
		logic [5:0][15:0] axes;
		open_session(8'h3C);
		send_good_frame(32'd1);
		// same sequence again is stale
		send_frame(8'h3C, proto_version, INPUT_TYPE, last_seq, 16'h0, 16'h0,
			legal_axes(), FRAME_BYTES, 1'b1, 1'b0);
		open_session(8'h3C);
		// one axis just past the negative limit
		axes = legal_axes();
		axes[5] = 16'(-(int'(axis_limit) + 1));
		send_frame(8'h3C, proto_version, INPUT_TYPE, 32'd9, '0, '0, axes,
			FRAME_BYTES, 1'b1, 1'b0);
		open_session(8'h3C);
		// gamepad at the last byte drops the owner
		send_frame(8'h3C, proto_version, INPUT_TYPE, 32'd9, '0, '0,
			legal_axes(), 1, 1'b1, 1'b1);
		open_session(8'h3C);
		// frames from another socket
		send_frame(8'hC3, proto_version, INPUT_TYPE, 32'd9, '0, '0,
			legal_axes(), 1, 1'b1, 1'b0);
		send_frame(8'hC3, proto_version, INPUT_TYPE, 32'd9, '0, '0,
			legal_axes(), 1, 1'b1, 1'b1);
		// transport failure on a short frame
		send_frame(8'h3C, proto_version, INPUT_TYPE, 32'd9, '0, '0,
			legal_axes(), 2, 1'b0, 1'b0);
		open_session(8'h3C);
		// overlong frame runs the byte count into saturation
		send_frame(8'h3C, proto_version, INPUT_TYPE, 32'd9, '0, '0,
			legal_axes(), 32, 1'b1, 1'b0);
	endtask

	task automatic test_lease_ticks();
		open_session(8'h11);
		now_ms = lease_start + lease_timeout;
		send_event(REQ_TICK, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		now_ms = now_ms + 1;
		send_event(REQ_TICK, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		open_session(8'h12);
		send_event(REQ_TICK, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		open_session(8'h13);
		send_event(REQ_TICK, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
		send_event(REQ_TICK, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
	endtask

	// mostly well-formed sessions, some broken frames and noise
	task automatic test_random_traffic(int items);
		int sent;
		int pick;
		sent = 0;
		while (sent < items) begin
			if (!owner_valid && $urandom_range(0, 3) != 0) begin
				open_session(8'($urandom));
				sent++;
				continue;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_good_frame($urandom_range(0, 9) == 0 ? $urandom & 32'h7FFF_FFFF :
					$urandom_range(1, 3000));
				sent += FRAME_BYTES;
			end else if (pick < 65) begin
				send_frame(owner_socket, 8'($urandom), 8'($urandom), $urandom,
					16'($urandom), 16'($urandom), {$urandom, $urandom, $urandom},
					$urandom_range(1, 34), 1'($urandom_range(0, 1)),
					$urandom_range(0, 4) == 0);
				sent += FRAME_BYTES;
			end else if (pick < 75) begin
				send_event(REQ_OPEN, 8'($urandom), $urandom_range(0, 3) == 0,
					$urandom_range(0, 3) == 0, 8'($urandom), 1'($urandom_range(0, 1)),
					1'b1);
				sent++;
			end else if (pick < 88) begin
				if ($urandom_range(0, 4) == 0) now_ms = $urandom;
				else advance_time(0, 2 * lease_timeout + 2);
				send_event(REQ_TICK, 8'($urandom), $urandom_range(0, 7) == 0,
					$urandom_range(0, 7) == 0, 8'($urandom), 1'($urandom_range(0, 1)),
					1'b0);
				sent++;
			end else if (pick < 94) begin
				send_event(REQ_CLOSE, $urandom_range(0, 1) ? owner_socket : 8'($urandom),
					1'b0, 1'b0, 8'($urandom), 1'b0, 1'b1);
				sent++;
			end else begin
				send_event(REQ_BYTE, 8'($urandom), 1'b0, 1'b0, 8'($urandom),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	// result side: random stalls and comparison against the oldest expectation
	always @(posedge clk) begin
		guard_result_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: kind %0d data %h", m_tuser, m_tdata);
				end else begin
					e = expected_results.pop_front();
					if (m_tuser != e.kind || m_tdata[2:0] != e.code ||
							m_tdata[4:3] != e.flags || m_tdata[36:5] != e.seq ||
							m_tdata[52:37] != e.held || m_tdata[84:53] != e.stream ||
							m_tdata[88:85] != e.idx || m_tdata[104:89] != e.axis ||
							m_tdata[120:105] != e.press || m_tdata[121] != e.close ||
							m_tlast != e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected kind %0d code %0d flags %0d ",
								"seq %h held %h stream %h idx %0d axis %h press %h close %b ",
								"last %b / got kind %0d code %0d flags %0d seq %h held %h ",
								"stream %h idx %0d axis %h press %h close %b last %b"},
								e.kind, e.code, e.flags, e.seq, e.held, e.stream, e.idx,
								e.axis, e.press, e.close, e.last, m_tuser, m_tdata[2:0],
								m_tdata[4:3], m_tdata[36:5], m_tdata[52:37], m_tdata[84:53],
								m_tdata[88:85], m_tdata[104:89], m_tdata[120:105],
								m_tdata[121], m_tlast);
					end
				end
			end
			m_tready <= $urandom_range(0, 99) >= sink_stall_pct;
		end
	end

	// watchdog
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[remote_frame_session_guard] ERROR");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		sender_idle_pct = 23;
		sink_stall_pct = 77;
		now_ms = 32'hFFFF_FF00;
		lease_timeout = 16'd500;
		ack_interval = 16'd200;
		axis_limit = 15'd1000;
		proto_version = 8'd1;
		clear_session();
		session_count = '0;
		byte_count = '0;
		for (int i = 0; i < FRAME_BYTES; i++) frame_bytes[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults straight out of reset
		test_open_rules();
		test_frame_checks();
		test_lease_ticks();

		set_regs(16'hFFFF, 16'h0000, 16'h7FFF, 16'h00FF);
		test_random_traffic(8);

		// hold off until the block has drained everything
		wait_idle();
		sender_idle_pct = 77;
		sink_stall_pct = 23;
		set_regs(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
		test_lease_ticks();
		test_random_traffic(8);

		sender_idle_pct = 0;
		sink_stall_pct = 0;
		set_regs(16'd300, 16'd50, 16'd1500, 16'h0001);
		test_random_traffic(8);

		wait_idle();
		if (mismatches == 0) begin
			$display("[remote_frame_session_guard] OK");
		end else begin
			$display("[remote_frame_session_guard] ERROR");
		end
		$finish;
	end

endmodule
